// ===== hdl/mau_pkg.sv =====
// mau_pkg: shared widths, mode codes and reset value for the modular arithmetic unit
// used by mau_reduce, mau_mulmod and modular_arithmetic_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

	localparam int MB   = 31;
	localparam int OP_W = 63;
	localparam int MODE_W = 3;
	localparam int OUT_W  = 31;
	localparam int CFG_W  = 31;

	localparam logic [MB-1:0] MOD_RESET = MB'(31'd1000000007);

	localparam logic [MODE_W-1:0] MODE_POW = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INV = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUB = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MUL = 3'd4;

	typedef logic [MB-1:0] res_t;

endpackage
`default_nettype wire

// ===== hdl/modular_arithmetic_unit.sv =====
// modular_arithmetic_unit: top level, sequencer with one serial reducer and two serial
// modular multipliers; depends on mau_pkg, mau_reduce, mau_mulmod
//
// Computes one result word per input word modulo the configured modulus (reset
// 1000000007): mode 0 power a^b, mode 1 inverse a^(m-2), modes 2..4 add, subtract and
// multiply of the reduced operands; modulus below 2 or an unused mode gives 0. One word is
// in work at a time; in_ready is high while the sequencer is idle, and the output register
// lets the next word start while a result waits. The sequencer first reduces operand_a,
// then operand_b in modes 2..4, and then forms the product in mode 4; for power and
// inverse it runs one square-and-multiply step per exponent bit up to the highest set
// bit, and two multipliers run the square and the multiply side by side.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit
	import mau_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [OP_W-1:0]   operand_a,
	input  wire logic [OP_W-1:0]   operand_b,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OUT_W-1:0]       result
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RA    = 3'd1;
	localparam logic [2:0] S_RB    = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_PCHK  = 3'd4;
	localparam logic [2:0] S_PSTEP = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]        state_q;
	res_t              mod_q;
	logic [MODE_W-1:0] mode_q;
	logic [OP_W-1:0]   b_q;
	logic [OP_W-1:0]   e_q;
	res_t              ar_q;
	res_t              acc_q;
	res_t              sq_q;
	res_t              res_q;
	logic [OUT_W-1:0]  result_q;
	logic              out_valid_q;

	logic            accept;
	logic            red_start;
	logic [OP_W-1:0] red_val;
	logic            red_done;
	res_t            red_r;
	logic            mul1_start;
	logic            mul2_start;
	res_t            mul1_x;
	res_t            mul1_y;
	logic            mul1_done;
	logic            mul2_done;
	res_t            p1;
	res_t            p2;
	logic            m_small;
	logic            is_pow;
	logic            bad_mode;
	logic [MB:0]     add_s;
	logic [MB:0]     add_r;
	logic [MB:0]     sub_r;
	logic            out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign m_small  = (mod_q < MB'(2));
	assign is_pow   = (mode_q == MODE_POW) || (mode_q == MODE_INV);
	assign bad_mode = !(mode_q inside {MODE_POW, MODE_INV, MODE_ADD, MODE_SUB, MODE_MUL});
	assign out_free = !out_valid_q || out_ready;

	assign red_start = accept ||
		(state_q == S_RA && red_done && !m_small && !bad_mode && !is_pow);
	assign red_val   = (state_q == S_IDLE) ? operand_a : b_q;

	assign mul1_start = (state_q == S_PCHK && e_q != '0) ||
		(state_q == S_RB && red_done && mode_q == MODE_MUL);
	assign mul2_start = (state_q == S_PCHK && e_q != '0);
	assign mul1_x     = (state_q == S_RB) ? ar_q : acc_q;
	assign mul1_y     = (state_q == S_RB) ? red_r : sq_q;

	always_comb begin
		add_s = {1'b0, ar_q} + {1'b0, red_r};
		if (add_s >= {1'b0, mod_q}) begin
			add_r = add_s - {1'b0, mod_q};
		end else begin
			add_r = add_s;
		end
		if (ar_q >= red_r) begin
			sub_r = {1'b0, ar_q} - {1'b0, red_r};
		end else begin
			sub_r = {1'b0, ar_q} + {1'b0, mod_q} - {1'b0, red_r};
		end
	end

	mau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.val    (red_val),
		.m      (mod_q),
		.done   (red_done),
		.r      (red_r)
	);

	mau_mulmod u_mul_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul1_start),
		.x      (mul1_x),
		.y      (mul1_y),
		.m      (mod_q),
		.done   (mul1_done),
		.p      (p1)
	);

	mau_mulmod u_mul_sq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul2_start),
		.x      (sq_q),
		.y      (sq_q),
		.m      (mod_q),
		.done   (mul2_done),
		.p      (p2)
	);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			mod_q <= cfg_wdata[MB-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RA;
					end
				end
				S_RA: begin
					if (red_done) begin
						if (m_small || bad_mode) begin
							state_q <= S_FIN;
						end else if (is_pow) begin
							state_q <= S_PCHK;
						end else begin
							state_q <= S_RB;
						end
					end
				end
				S_RB: begin
					if (red_done) begin
						state_q <= (mode_q == MODE_MUL) ? S_MUL : S_FIN;
					end
				end
				S_MUL: begin
					if (mul1_done) begin
						state_q <= S_FIN;
					end
				end
				S_PCHK: begin
					state_q <= (e_q == '0) ? S_FIN : S_PSTEP;
				end
				S_PSTEP: begin
					if (mul1_done) begin
						state_q <= S_PCHK;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q <= mode;
					b_q    <= operand_b;
				end
			end
			S_RA: begin
				if (red_done) begin
					ar_q  <= red_r;
					sq_q  <= red_r;
					acc_q <= MB'(1);
					res_q <= '0;
					e_q   <= (mode_q == MODE_POW) ? b_q : OP_W'(mod_q - MB'(2));
				end
			end
			S_RB: begin
				if (red_done) begin
					res_q <= (mode_q == MODE_ADD) ? add_r[MB-1:0] : sub_r[MB-1:0];
				end
			end
			S_MUL: begin
				if (mul1_done) begin
					res_q <= p1;
				end
			end
			S_PCHK: begin
				if (e_q == '0) begin
					res_q <= acc_q;
				end
			end
			S_PSTEP: begin
				if (mul1_done) begin
					if (e_q[0]) begin
						acc_q <= p1;
					end
					sq_q <= p2;
					e_q  <= {1'b0, e_q[OP_W-1:1]};
				end
			end
			S_FIN: begin
				if (out_free) begin
					result_q <= OUT_W'(res_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_red_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		red_done |-> (state_q == S_RA || state_q == S_RB))
		else $error("reducer finished outside a reduce state");

	a_mul_done_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		mul1_done |-> (state_q == S_MUL || state_q == S_PSTEP))
		else $error("multiplier finished outside a multiply state");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PSTEP) |-> (mul1_done == mul2_done))
		else $error("square and multiply units out of step");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !m_small) |-> (res_q < mod_q))
		else $error("result not reduced below modulus");

endmodule
`default_nettype wire

// ===== hdl/mau_reduce.sv =====
// mau_reduce: bit-serial restoring reduction of a 63-bit operand modulo m
// one operand bit per cycle, msb first; depends on mau_pkg
`timescale 1ns / 1ps
`default_nettype none
module mau_reduce
	import mau_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [OP_W-1:0] val,
	input  wire res_t            m,
	output logic                 done,
	output res_t                 r
);

	localparam int CNT_W = $clog2(OP_W);

	logic [OP_W-1:0]  val_q;
	res_t             r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MB:0]      nxt;
	logic [MB:0]      nxt_red;

	always_comb begin
		nxt = {r_q, val_q[OP_W-1]};
		if (nxt >= {1'b0, m}) begin
			nxt_red = nxt - {1'b0, m};
		end else begin
			nxt_red = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(OP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= val;
			r_q   <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[OP_W-2:0], 1'b0};
			r_q   <= nxt_red[MB-1:0];
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule
`default_nettype wire

// ===== hdl/mau_mulmod.sv =====
// mau_mulmod: bit-serial interleaved modular multiplier, x*y mod m
// one multiplier bit per cycle, msb first; depends on mau_pkg
`timescale 1ns / 1ps
`default_nettype none
module mau_mulmod
	import mau_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire res_t x,
	input  wire res_t y,
	input  wire res_t m,
	output logic      done,
	output res_t      p
);

	localparam int CNT_W = $clog2(MB + 1);

	res_t             x_q;
	res_t             y_q;
	res_t             r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MB:0]      dbl;
	logic [MB:0]      dbl_red;
	logic [MB:0]      sum;
	logic [MB:0]      sum_red;

	always_comb begin
		dbl = {r_q, 1'b0};
		if (dbl >= {1'b0, m}) begin
			dbl_red = dbl - {1'b0, m};
		end else begin
			dbl_red = dbl;
		end
		sum = dbl_red + (y_q[MB-1] ? {1'b0, x_q} : '0);
		if (sum >= {1'b0, m}) begin
			sum_red = sum - {1'b0, m};
		end else begin
			sum_red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			r_q <= '0;
		end else if (busy_q) begin
			y_q <= {y_q[MB-2:0], 1'b0};
			r_q <= sum_red[MB-1:0];
		end
	end

	assign done = done_q;
	assign p    = r_q;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for modular_arithmetic_unit (power, inverse, add, sub, mul)
// depends on mau_pkg and modular_arithmetic_unit; carries its own prediction of each word
`timescale 1ns / 1ps
module testbench
	import mau_pkg::*;
();

	localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam logic [OP_W-1:0]   OP_ONES      = {OP_W{1'b1}};
	localparam logic [CFG_W-1:0]  MOD_MAX      = {CFG_W{1'b1}};

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [MODE_W-1:0] mode      = '0;
	logic [OP_W-1:0]   operand_a = '0;
	logic [OP_W-1:0]   operand_b = '0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic [OUT_W-1:0]  result;

	logic [OUT_W-1:0] expected_results[$];
	logic [CFG_W-1:0] modulus_model = CFG_W'(MOD_RESET);
	bit               pacing_on     = 1'b1;
	int               mismatch_count = 0;

	modular_arithmetic_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic bit [63:0] mod_power(bit [63:0] base, bit [63:0] ex, bit [63:0] m);
		bit [63:0] acc;
		bit [63:0] sq;
		acc = 64'd1 % m;
		sq = base % m;
		for (int i = 0; i < 63; i++) begin
			if (ex[i])
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc;
	endfunction

	function automatic logic [OUT_W-1:0] predict_result(logic [MODE_W-1:0] op,
			logic [OP_W-1:0] a, logic [OP_W-1:0] b, logic [CFG_W-1:0] m);
		bit [63:0] m64;
		bit [63:0] ar;
		bit [63:0] br;
		bit [63:0] r;
		m64 = 64'(m);
		if (m64 < 64'd2)
			return '0;
		ar = 64'(a) % m64;
		br = 64'(b) % m64;
		case (op)
			MODE_POW: r = mod_power(64'(a), 64'(b), m64);
			MODE_INV: r = mod_power(64'(a), m64 - 64'd2, m64);
			MODE_ADD: r = (ar + br) % m64;
			MODE_SUB: r = (ar + m64 - br) % m64;
			MODE_MUL: r = (ar * br) % m64;
			default:  r = '0;
		endcase
		return OUT_W'(r);
	endfunction

	function automatic logic [OP_W-1:0] rand63();
		return OP_W'({$urandom, $urandom});
	endfunction

	function automatic logic [OP_W-1:0] pick_operand(logic [CFG_W-1:0] m);
		logic [OP_W-1:0] mw;
		mw = OP_W'(m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return OP_ONES;
			2: return mw - 1'b1;
			3: return mw;
			4: return OP_W'($urandom_range(0, 20));
			5: return mw * $urandom_range(1, 1000) + $urandom_range(0, 3);
			default: return rand63();
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_exponent();
		int len;
		case ($urandom_range(0, 19))
			0: return '0;
			1: return OP_ONES;
			2: return rand63();
			default: begin
				len = $urandom_range(1, 20);
				return OP_W'(64'(rand63()) & ((64'd1 << len) - 64'd1));
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: error: %s", $time, what);
		mismatch_count++;
	endtask

	// result side: each returned word against the oldest prediction
	always @(posedge clk) begin : result_check
		logic [OUT_W-1:0] want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with no word outstanding", result));
			end else begin
				want = expected_results.pop_front();
				if (result !== want)
					report_mismatch($sformatf("result %0d, predicted %0d", result, want));
			end
		end
	end

	// result side stalls
	initial begin : result_pacing
		int stall;
		forever begin
			@(posedge clk);
			if (pacing_on && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 9);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [MODE_W-1:0] op, input logic [OP_W-1:0] a,
			input logic [OP_W-1:0] b);
		int gap;
		gap = 0;
		if (pacing_on && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 9);
		repeat (gap + 1) @(posedge clk);
		mode      <= op;
		operand_a <= a;
		operand_b <= b;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		expected_results = {expected_results, predict_result(op, a, b, modulus_model)};
		in_valid <= 1'b0;
	endtask

	task automatic send_random_word();
		logic [MODE_W-1:0] op;
		logic [OP_W-1:0]   a;
		logic [OP_W-1:0]   b;
		if ($urandom_range(0, 19) == 0)
			op = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
		else
			op = MODE_W'($urandom_range(MODE_POW, MODE_MUL));
		a = pick_operand(modulus_model);
		b = (op == MODE_POW) ? pick_exponent() : pick_operand(modulus_model);
		send_word(op, a, b);
	endtask

	task automatic wait_drain();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [CFG_W-1:0] value);
		wait_drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		modulus_model = value;
	endtask

	task automatic test_reset_modulus();
		send_word(MODE_POW, 63'd2, 63'd10);
		send_word(MODE_POW, 63'd12345, '0);
		send_word(MODE_POW, '0, '0);
		send_word(MODE_POW, OP_ONES, OP_ONES);
		send_word(MODE_INV, '0, 63'd5);
		send_word(MODE_INV, 63'd2, OP_ONES);
		send_word(MODE_INV, OP_ONES, '0);
		send_word(MODE_ADD, OP_ONES, OP_ONES);
		send_word(MODE_SUB, '0, OP_ONES);
		send_word(MODE_SUB, 63'd5, 63'd5);
		send_word(MODE_MUL, OP_ONES, OP_ONES);
		send_word(MODE_MUL, 63'd1000000006, 63'd1000000006);
		send_word(MODE_SPARE_5, OP_ONES, OP_ONES);
		send_word(MODE_SPARE_6, 63'd3, 63'd4);
		send_word(MODE_SPARE_7, OP_ONES, '0);
	endtask

	task automatic test_modulus_extremes();
		write_modulus(31'd2);
		send_word(MODE_INV, 63'd7, 63'd9);
		send_word(MODE_POW, 63'd3, OP_ONES);
		send_word(MODE_ADD, 63'd1, 63'd1);
		write_modulus(MOD_MAX);
		send_word(MODE_INV, 63'd3, '0);
		send_word(MODE_MUL, 63'd2147483646, 63'd2147483646);
		send_word(MODE_POW, 63'd3, OP_ONES);
		write_modulus('0);
		send_word(MODE_POW, 63'd5, 63'd3);
		send_word(MODE_INV, 63'd5, '0);
		write_modulus(31'd1);
		send_word(MODE_ADD, 63'd3, 63'd4);
		send_word(MODE_MUL, 63'd6, 63'd7);
	endtask

	task automatic test_random_moduli();
		logic [CFG_W-1:0] mods [6];
		mods[0] = 31'd998244353;
		mods[1] = MOD_MAX;
		mods[2] = CFG_W'($urandom_range(2, 1000));
		mods[3] = CFG_W'($urandom_range(2, 32'h7FFF_FFFF));
		mods[4] = 31'h4000_0000;
		mods[5] = CFG_W'(MOD_RESET);
		for (int p = 0; p < 6; p++) begin
			write_modulus(mods[p]);
			pacing_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 38; k++)
				send_random_word();
		end
	endtask

	// sender holds off until every outstanding word has returned
	task automatic test_drained_sends();
		pacing_on = 1'b1;
		for (int k = 0; k < 6; k++) begin
			wait_drain();
			repeat ($urandom_range(1, 20)) @(posedge clk);
			send_random_word();
		end
	endtask

	task automatic test_no_idle_tail();
		pacing_on = 1'b0;
		for (int k = 0; k < 30; k++)
			send_random_word();
	endtask

	initial begin : main
		int spins;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_modulus();
		test_modulus_extremes();
		test_random_moduli();
		test_drained_sends();
		test_no_idle_tail();
		spins = 0;
		while (expected_results.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d words never returned", expected_results.size()));
		repeat (2200) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mau_pkg.sv
hdl/mau_reduce.sv
hdl/mau_mulmod.sv
hdl/modular_arithmetic_unit.sv
tb/sv/testbench.sv
